// ===== sv/sawbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sawbc_pkg
// Shared constants and controller/datapath types for the write-back cache.
// ----------------------------------------------------------------------------
package sawbc_pkg;

    localparam int SETS      = 10;
    localparam int WAYS      = 6;
    localparam int ADDR_BITS = 16;
    localparam int AGE_BITS  = 16;

    typedef enum logic [7:0] {
        S_CLR    = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_MOD    = 8'b0000_1000,
        S_SET    = 8'b0001_0000,
        S_READ   = 8'b0010_0000,
        S_LOOK   = 8'b0100_0000,
        S_COMMIT = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic modr;
        logic set;
        logic read;
        logic look;
        logic commit;
        logic clr;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
        logic is_write;
    } t_sts;

endpackage

// ===== sv/sawbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sawbc_ctrl
// Sequencer: backing store clear after reset, then one access at a time.
// ----------------------------------------------------------------------------
module sawbc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  sawbc_pkg::t_sts i_sts,
    output logic            o_s_tready,
    output sawbc_pkg::t_cmd o_cmd
);

    sawbc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sawbc_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == sawbc_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            sawbc_pkg::S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = sawbc_pkg::S_IDLE;
            end
            sawbc_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sawbc_pkg::S_MUL;
                end
            end
            sawbc_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = sawbc_pkg::S_MOD;
            end
            sawbc_pkg::S_MOD: begin
                o_cmd.modr = 1'b1;
                n_state    = sawbc_pkg::S_SET;
            end
            sawbc_pkg::S_SET: begin
                o_cmd.set = 1'b1;
                n_state   = sawbc_pkg::S_READ;
            end
            sawbc_pkg::S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = sawbc_pkg::S_LOOK;
            end
            sawbc_pkg::S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = sawbc_pkg::S_COMMIT;
            end
            sawbc_pkg::S_COMMIT: begin
                if (i_sts.is_write || !i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = sawbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sawbc_pkg::S_CLR;
            end
        endcase
    end

endmodule

// ===== sv/sawbc_dp.sv =====
// ----------------------------------------------------------------------------
// sawbc_dp
// Datapath: set index, set row memory, age-based victim pick, backing store.
// ----------------------------------------------------------------------------
module sawbc_dp #(
    parameter int SETS      = sawbc_pkg::SETS,
    parameter int WAYS      = sawbc_pkg::WAYS,
    parameter int ADDR_BITS = sawbc_pkg::ADDR_BITS,
    parameter int AGE_BITS  = sawbc_pkg::AGE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sawbc_pkg::t_cmd      i_cmd,
    input  logic                 i_func,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [7:0]           i_write_data,
    input  logic                 i_m_tready,
    output sawbc_pkg::t_sts      o_sts,
    output logic                 o_m_tvalid,
    output logic [7:0]           o_read_data,
    output logic                 o_hit,
    output logic                 o_dirty_flag
);

    localparam int TAG_BITS  = ADDR_BITS - 2;
    localparam int MEM_WORDS = 2 ** TAG_BITS;
    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W     = $clog2(WAYS);
    localparam int LVLS      = $clog2(WAYS);
    localparam int TREE_N    = 2 ** LVLS;
    localparam int SETS_W    = $clog2(SETS + 1);
    localparam logic [TAG_BITS:0]   RECIP   = (TAG_BITS+1)'((2 ** TAG_BITS) / SETS);
    localparam logic [SETS_W-1:0]   SETS_C  = SETS_W'(SETS);
    localparam logic [TAG_BITS-1:0] SETS_T  = TAG_BITS'(SETS);

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         data;
        logic                dirty;
        logic [AGE_BITS-1:0] age;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    t_row                r_row_mem [SETS];
    logic [31:0]         r_bk_mem  [MEM_WORDS];
    logic [SETS-1:0]     r_row_vld;

    logic                r_func;
    logic [TAG_BITS-1:0] r_tag;
    logic [1:0]          r_off;
    logic [7:0]          r_wdata;
    logic [TAG_BITS-1:0] r_q;
    logic [TAG_BITS-1:0] r_rem;
    logic [SET_W-1:0]    r_set;
    t_row                r_row_q;
    logic                r_row_ok;
    logic [31:0]         r_bk_q;
    logic                r_hit;
    logic [WAY_W-1:0]    r_way;
    logic [TAG_BITS-1:0] r_clr_cnt;
    logic                r_out_vld;
    logic [7:0]          r_out_data;
    logic                r_out_hit;
    logic                r_out_dirty;

    logic [2*TAG_BITS:0]        mul_p;
    logic [TAG_BITS+SETS_W-1:0] qs_p;
    logic [TAG_BITS-1:0]        rem_c;
    t_row                       row;
    logic                       hit_c;
    logic [WAY_W-1:0]           hit_way;
    logic [WAY_W-1:0]           t_idx [LVLS+1][TREE_N];
    logic [AGE_BITS-1:0]        t_age [LVLS+1][TREE_N];
    logic                       t_ok  [LVLS+1][TREE_N];
    t_way                       used;
    logic [31:0]                line;
    logic [31:0]                line_new;
    t_row                       row_new;

    assign mul_p = r_tag * RECIP;
    assign qs_p  = r_q * SETS_C;
    assign rem_c = (r_rem >= SETS_T) ? r_rem - SETS_T : r_rem;

    always_comb begin
        row     = r_row_ok ? r_row_q : '0;
        hit_c   = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row[w].tag == r_tag) begin
                hit_c   = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        for (int l = 0; l <= LVLS; l++) begin
            for (int i = 0; i < TREE_N; i++) begin
                t_idx[l][i] = '0;
                t_age[l][i] = '0;
                t_ok[l][i]  = 1'b0;
            end
        end
        for (int i = 0; i < WAYS; i++) begin
            t_idx[0][i] = WAY_W'(i);
            t_age[0][i] = row[i].age;
            t_ok[0][i]  = 1'b1;
        end
        for (int l = 1; l <= LVLS; l++) begin
            for (int i = 0; i < TREE_N / 2; i++) begin
                if (t_ok[l-1][2*i+1] &&
                    (!t_ok[l-1][2*i] || t_age[l-1][2*i+1] > t_age[l-1][2*i])) begin
                    t_idx[l][i] = t_idx[l-1][2*i+1];
                    t_age[l][i] = t_age[l-1][2*i+1];
                    t_ok[l][i]  = 1'b1;
                end else begin
                    t_idx[l][i] = t_idx[l-1][2*i];
                    t_age[l][i] = t_age[l-1][2*i];
                    t_ok[l][i]  = t_ok[l-1][2*i];
                end
            end
        end
    end

    always_comb begin
        used     = row[r_way];
        line     = r_hit ? used.data : r_bk_q;
        line_new = line;
        for (int b = 0; b < 4; b++) begin
            if (r_func && r_off == 2'(b)) line_new[8*b +: 8] = r_wdata;
        end
        row_new = row;
        for (int w = 0; w < WAYS; w++) begin
            if (r_way == WAY_W'(w)) begin
                row_new[w].tag   = r_tag;
                row_new[w].data  = line_new;
                row_new[w].dirty = r_func | (r_hit & used.dirty);
                row_new[w].age   = '0;
            end else if (row[w].age != '1) begin
                row_new[w].age = row[w].age + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_tag   <= i_address[ADDR_BITS-1:2];
            r_off   <= i_address[1:0];
            r_wdata <= i_write_data;
        end
        if (i_cmd.mul)  r_q   <= mul_p[2*TAG_BITS-1:TAG_BITS];
        if (i_cmd.modr) r_rem <= r_tag - qs_p[TAG_BITS-1:0];
        if (i_cmd.set)  r_set <= rem_c[SET_W-1:0];
        if (i_cmd.read) begin
            r_row_q  <= r_row_mem[r_set];
            r_row_ok <= r_row_vld[r_set];
        end
        if (i_cmd.look) begin
            r_hit <= hit_c;
            r_way <= hit_c ? hit_way : t_idx[LVLS][0];
        end
        if (i_cmd.commit) begin
            r_row_mem[r_set] <= row_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_bk_q <= r_bk_mem[r_tag];
        end
        if (i_cmd.clr) begin
            r_bk_mem[r_clr_cnt] <= '0;
        end else if (i_cmd.commit && !r_hit && used.dirty) begin
            r_bk_mem[used.tag] <= used.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_clr_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cmd.commit) r_row_vld[r_set] <= 1'b1;
            if (i_cmd.commit && !r_func) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_func) begin
            r_out_data  <= line[8*r_off +: 8];
            r_out_hit   <= r_hit;
            r_out_dirty <= used.dirty;
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == '1);
    assign o_sts.out_busy = r_out_vld & ~i_m_tready;
    assign o_sts.is_write = r_func;

    assign o_m_tvalid   = r_out_vld;
    assign o_read_data  = r_out_data;
    assign o_hit        = r_out_hit;
    assign o_dirty_flag = r_out_dirty;

endmodule

// ===== sv/set_assoc_writeback_cache.sv =====
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache
// Set-associative write-back byte cache with age-based replacement.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            contents
//  s_axis    in    i_s_tvalid/o_s_tready tuser func, tdata address, write_data
//  m_axis    out   o_m_tvalid/i_m_tready tdata read_data, hit, dirty_flag
//
//  Each item goes through accept, set index by reciprocal multiply, memory
//  read, tag compare and victim pick, and row/backing update, in that order.
//  Reads give one item; writes give none.
//  After reset the backing store is cleared, one word a cycle, all
//  2^(ADDR_BITS-2) words (16384 by default); no item is taken meanwhile.
//  A read holds in its update step while the output register is still full.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache #(
    parameter int SETS      = sawbc_pkg::SETS,
    parameter int WAYS      = sawbc_pkg::WAYS,
    parameter int ADDR_BITS = sawbc_pkg::ADDR_BITS,
    parameter int AGE_BITS  = sawbc_pkg::AGE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((ADDR_BITS+8+7)/8)*8-1:0]    i_s_tdata,  // address, write_data
    input  logic                                i_s_tuser,  // func
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [15:0]                         o_m_tdata   // read_data, hit, dirty_flag
);

    sawbc_pkg::t_cmd cmd;
    sawbc_pkg::t_sts sts;
    logic [7:0]      read_data;
    logic            hit;
    logic            dirty_flag;

    sawbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    sawbc_dp #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS),
        .AGE_BITS  (AGE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_s_tuser),
        .i_address    (i_s_tdata[ADDR_BITS-1:0]),
        .i_write_data (i_s_tdata[ADDR_BITS+7:ADDR_BITS]),
        .i_m_tready   (i_m_tready),
        .o_sts        (sts),
        .o_m_tvalid   (o_m_tvalid),
        .o_read_data  (read_data),
        .o_hit        (hit),
        .o_dirty_flag (dirty_flag)
    );

    assign o_m_tdata = {6'b0, dirty_flag, hit, read_data};

endmodule

// ===== sim/tb_set_assoc_writeback_cache.sv =====
// ----------------------------------------------------------------------------
// tb_set_assoc_writeback_cache
// Streams byte reads and writes into the cache under bursty input and a
// stalling output, predicts every read result with a local cache model and
// compares read data, hit and dirty flag in order.
// ----------------------------------------------------------------------------
module tb_set_assoc_writeback_cache;

    localparam int SETS      = sawbc_pkg::SETS;
    localparam int WAYS      = sawbc_pkg::WAYS;
    localparam int ADDR_BITS = sawbc_pkg::ADDR_BITS;
    localparam int AGE_BITS  = sawbc_pkg::AGE_BITS;
    localparam int TAG_BITS  = ADDR_BITS - 2;
    localparam int DW        = ((ADDR_BITS + 8 + 7) / 8) * 8;
    localparam int LIMIT     = 200000;

    typedef struct packed {
        logic                 func;
        logic [ADDR_BITS-1:0] address;
        logic [7:0]           write_data;
    } t_access;

    typedef struct packed {
        logic [7:0] read_data;
        logic       hit;
        logic       dirty_flag;
    } t_read_result;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    logic [DW-1:0]   i_s_tdata = '0;
    logic            i_s_tuser = 1'b0;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    logic [15:0]     o_m_tdata;

    t_access      pending_q[$];
    t_read_result read_results_q[$];

    logic [TAG_BITS-1:0] tags   [SETS][WAYS];
    logic [31:0]         lines  [SETS][WAYS];
    logic                dirty  [SETS][WAYS];
    logic [AGE_BITS-1:0] ages   [SETS][WAYS];
    logic [31:0]         backing[1 << TAG_BITS];

    int  errors = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    bit  stim_done = 0;
    bit  in_reset = 1;

    set_assoc_writeback_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    task automatic enq_access(input t_access a);
        pending_q = {pending_q, a};
    endtask

    task automatic cache_access(input t_access a);
        int tag, off, s, way, w, best;
        bit hit;
        logic old_dirty;
        t_read_result r;
        tag = a.address >> 2;
        off = a.address[1:0];
        s = tag % SETS;
        way = WAYS;
        for (w = WAYS - 1; w >= 0; w--)
            if (tags[s][w] == tag) way = w;
        hit = way < WAYS;
        if (!hit) begin
            best = 0;
            for (w = 1; w < WAYS; w++)
                if (ages[s][best] < ages[s][w]) best = w;
            way = best;
            if (dirty[s][way]) backing[tags[s][way]] = lines[s][way];
            lines[s][way] = backing[tag];
        end
        old_dirty = dirty[s][way];
        if (a.func) begin
            lines[s][way][8*off +: 8] = a.write_data;
            tags[s][way] = tag;
            dirty[s][way] = 1'b1;
        end else begin
            r.read_data = lines[s][way][8*off +: 8];
            r.hit = hit;
            r.dirty_flag = old_dirty;
            read_results_q = {read_results_q, r};
            if (!hit) begin
                tags[s][way] = tag;
                dirty[s][way] = 1'b0;
            end
        end
        for (w = 0; w < WAYS; w++)
            if (ages[s][w] != {AGE_BITS{1'b1}}) ages[s][w]++;
        ages[s][way] = '0;
    endtask

    function automatic t_access mk(input bit f, input int addr, input int d);
        t_access a;
        a.func = f;
        a.address = addr[ADDR_BITS-1:0];
        a.write_data = d[7:0];
        return a;
    endfunction

    initial begin
        int i, k, base, tag;
        for (i = 0; i < SETS; i++)
            for (k = 0; k < WAYS; k++) begin
                tags[i][k] = '0; lines[i][k] = '0; dirty[i][k] = 0; ages[i][k] = '0;
            end
        for (i = 0; i < (1 << TAG_BITS); i++) backing[i] = '0;
        // directed: tag zero, extremes, set overflow with dirty victims
        enq_access(mk(0, 0, 0));
        enq_access(mk(1, 3, 255));
        enq_access(mk(0, 3, 0));
        enq_access(mk(1, 16'hFFFF, 8'hA5));
        enq_access(mk(0, 16'hFFFF, 0));
        enq_access(mk(0, 16'hFFFE, 0));
        for (i = 1; i <= 8; i++) enq_access(mk(1, i * SETS * 4 + 1, i * 17));
        for (i = 1; i <= 8; i++) enq_access(mk(0, i * SETS * 4 + 1, 0));
        enq_access(mk(0, 16'h1234, 8'hFF));
        enq_access(mk(0, 0, 0));
        // random: mostly a small hot set of tags to force hits and evictions
        for (i = 0; i < 1080; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                base = $urandom_range(0, 3);
                tag = $urandom_range(0, 2 * WAYS) * SETS + base;
                enq_access(mk($urandom_range(0, 1), tag * 4 + $urandom_range(0, 3),
                              $urandom_range(0, 255)));
            end else begin
                enq_access(mk($urandom_range(0, 1), $urandom_range(0, 65535),
                              $urandom_range(0, 255)));
            end
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_reset = 0;
    end

    always @(posedge i_clk) begin
        if (!in_reset) begin
            if (i_s_tvalid && o_s_tready) cache_access(pending_q.pop_front());
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_s_tvalid <= 1'b0;
                end else if (pending_q.size() > (i_s_tvalid && o_s_tready ? 0 : 0)) begin
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                    i_s_tvalid <= 1'b1;
                    i_s_tuser <= pending_q[0].func;
                    i_s_tdata <= {pending_q[0].write_data, pending_q[0].address};
                end else begin
                    i_s_tvalid <= 1'b0;
                    stim_done <= 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_read_result exp_r, got;
        if (!in_reset) begin
            i_m_tready <= ($urandom_range(0, 15) < 3) ? 1'b0 : (($time / 3000) % 3 != 1 ||
                          $urandom_range(0, 1));
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_m_tvalid && i_m_tready) begin
                got.read_data  = o_m_tdata[7:0];
                got.hit        = o_m_tdata[8];
                got.dirty_flag = o_m_tdata[9];
                if (read_results_q.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    exp_r = read_results_q.pop_front();
                    if (got.read_data !== exp_r.read_data ||
                        got.hit !== exp_r.hit || got.dirty_flag !== exp_r.dirty_flag) begin
                        $display({"%0t mismatch: expected data %h hit %b dirty %b, ",
                                  "actual data %h hit %b dirty %b"},
                                 $time, exp_r.read_data, exp_r.hit, exp_r.dirty_flag,
                                 got.read_data, got.hit, got.dirty_flag);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        wait (stim_done && read_results_q.size() == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && read_results_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sawbc_pkg.sv
sv/sawbc_ctrl.sv
sv/sawbc_dp.sv
sv/set_assoc_writeback_cache.sv
sim/tb_set_assoc_writeback_cache.sv
